/* sv/rha_pkg.sv */
// Shared constants and types for the RGB histogram accumulator.
`default_nettype none

package rha_pkg;

    localparam int BIN_COUNT  = 256;
    localparam int COUNT_BITS = 32;
    localparam int IDX_BITS   = $clog2(BIN_COUNT);
    localparam int OUT_BITS   = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [OUT_BITS-1:0]   OUT_MAX   = '1;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request fields
        logic fetch;    // read the three stores
        logic update;   // write back incremented counts
        logic wipe;     // zero one bin of each store, sweep address advances
        logic reply;    // drive result this cycle
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic item_read;
        logic wipe_last;    // sweep is on the last bin
    } dp_status_t;

endpackage

`default_nettype wire

/* sv/rgb_histogram_accumulator.sv */
// Top level of the RGB histogram accumulator: controller plus datapath.
`default_nettype none

// Three 256-bin saturating count stores (red, green, blue). A request is
// taken when start is high and busy is low; busy then stays high until the
// block can take the next one. Per command:
//   pixel  - read of the three bins, then write-back of incremented counts.
//   read   - read of the three bins, then done pulses for one cycle,
//            carrying bin_count and bin_in_range; the receiver cannot
//            stall it, so capture it on that cycle.
//   clear  - sweeps all 256 bins, one per cycle. Unused command code 3 is
//            dropped with busy staying low.
// A pixel reads and writes back the stores in separate states. Reset runs the
// same clearing sweep: busy is high during reset and through the sweep
// that follows the rise of rst_n, so the first request can be taken once
// that sweep is done. max_level is written with max_level_we; the user
// must write it only while the block is idle: the block does not enforce it.

module rgb_histogram_accumulator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  red_level,
    input  wire logic [7:0]  green_level,
    input  wire logic [7:0]  blue_level,
    input  wire logic [1:0]  channel,
    input  wire logic [7:0]  bin_index,
    input  wire logic        max_level_we,
    input  wire logic [7:0]  max_level,
    output logic             done,
    output logic [31:0]      bin_count,
    output logic             bin_in_range
);

    rha_pkg::ctrl_cmd_t  ctl;
    rha_pkg::dp_status_t status;

    // request sequencing
    rha_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .status (status),
        .ctl    (ctl),
        .busy   (busy)
    );

    // stores and result path
    rha_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .status       (status),
        .cmd          (cmd),
        .red_level    (red_level),
        .green_level  (green_level),
        .blue_level   (blue_level),
        .channel      (channel),
        .bin_index    (bin_index),
        .max_level_we (max_level_we),
        .max_level    (max_level),
        .bin_count    (bin_count),
        .bin_in_range (bin_in_range),
        .done         (done)
    );

endmodule

`default_nettype wire

/* sv/rha_ctrl.sv */
// Sequencing state machine for the RGB histogram accumulator.
`default_nettype none

module rha_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [1:0]          cmd,
    input  wire rha_pkg::dp_status_t status,
    output rha_pkg::ctrl_cmd_t       ctl,
    output logic                     busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_UPDATE,
        S_REPLY,
        S_WIPE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        rha_pkg::CMD_PIXEL: state_next = S_FETCH;
                        rha_pkg::CMD_READ:  state_next = S_FETCH;
                        rha_pkg::CMD_CLEAR: state_next = S_WIPE;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_FETCH:  state_next = status.item_read ? S_REPLY : S_UPDATE;
            S_UPDATE: state_next = S_IDLE;
            S_REPLY:  state_next = S_IDLE;
            S_WIPE:   state_next = status.wipe_last ? S_IDLE : S_WIPE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl        = '0;
        ctl.load   = (state_reg == S_IDLE) && start;
        ctl.fetch  = (state_reg == S_FETCH);
        ctl.update = (state_reg == S_UPDATE);
        ctl.reply  = (state_reg == S_REPLY);
        ctl.wipe   = (state_reg == S_WIPE);
    end

    // reset starts a clearing sweep of the stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WIPE;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

/* sv/rha_datapath.sv */
// Request registers, per-channel count stores and result logic.
`default_nettype none

module rha_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rha_pkg::ctrl_cmd_t  ctl,
    output rha_pkg::dp_status_t      status,
    input  wire logic [1:0]          cmd,
    input  wire logic [7:0]          red_level,
    input  wire logic [7:0]          green_level,
    input  wire logic [7:0]          blue_level,
    input  wire logic [1:0]          channel,
    input  wire logic [7:0]          bin_index,
    input  wire logic                max_level_we,
    input  wire logic [7:0]          max_level,
    output logic [31:0]              bin_count,
    output logic                     bin_in_range,
    output logic                     done
);

    localparam int IW = rha_pkg::IDX_BITS;
    localparam int CW = rha_pkg::COUNT_BITS;

    logic [1:0] cmd_reg;
    logic [1:0] channel_reg;
    logic [7:0] bin_index_reg;
    logic [7:0] sample_reg [3];
    logic [7:0] max_level_reg;

    logic [CW-1:0] rdata_reg  [3];
    logic [IW-1:0] wipe_addr_reg;

    // request capture
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg       <= cmd;
            channel_reg   <= channel;
            bin_index_reg <= bin_index;
            sample_reg[0] <= red_level;
            sample_reg[1] <= green_level;
            sample_reg[2] <= blue_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_level_reg <= 8'd255;
        else if (max_level_we)
            max_level_reg <= max_level;
    end

    // clearing sweep address, one bin per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wipe_addr_reg <= '0;
        else if (ctl.wipe)
            wipe_addr_reg <= status.wipe_last ? '0 : wipe_addr_reg + IW'(1);
    end

    assign status.item_read = (cmd_reg == rha_pkg::CMD_READ);
    assign status.wipe_last = (wipe_addr_reg == IW'(rha_pkg::BIN_COUNT - 1));

    for (genvar c = 0; c < 3; c++)
    begin : g_store
        logic [CW-1:0] mem [rha_pkg::BIN_COUNT];
        logic [IW-1:0] addr;
        logic          in_store;
        logic [CW-1:0] cur;
        logic [CW-1:0] count_next;
        logic          we;
        logic [IW-1:0] waddr;
        logic [CW-1:0] wdata;

        assign in_store = (32'(sample_reg[c]) < 32'(rha_pkg::BIN_COUNT));
        assign addr     = status.item_read ? IW'(bin_index_reg) : IW'(sample_reg[c]);
        assign cur      = rdata_reg[c];
        assign count_next = (cur == rha_pkg::COUNT_MAX) ? cur : cur + CW'(1);

        assign we    = ctl.wipe || (ctl.update && in_store);
        assign waddr = ctl.wipe ? wipe_addr_reg : addr;
        assign wdata = ctl.wipe ? '0 : count_next;

        always_ff @(posedge clk)
        begin
            if (ctl.fetch)
                rdata_reg[c] <= mem[addr];
            if (we)
                mem[waddr] <= wdata;
        end
    end

    logic          in_range;
    logic          idx_ok;
    logic [CW-1:0] sel_count;
    logic [63:0]   sel_ext;

    assign in_range = (bin_index_reg <= max_level_reg);
    assign idx_ok   = (32'(bin_index_reg) < 32'(rha_pkg::BIN_COUNT));

    always_comb
    begin
        sel_count = '0;
        if (in_range && idx_ok)
        begin
            case (channel_reg)
                rha_pkg::CH_RED:   sel_count = rdata_reg[0];
                rha_pkg::CH_GREEN: sel_count = rdata_reg[1];
                rha_pkg::CH_BLUE:  sel_count = rdata_reg[2];
                default:           sel_count = '0;
            endcase
        end
        sel_ext = 64'(sel_count);
    end

    assign bin_count    = (sel_ext > 64'(rha_pkg::OUT_MAX)) ? rha_pkg::OUT_MAX
                                                            : sel_ext[31:0];
    assign bin_in_range = in_range;
    assign done         = ctl.reply;

endmodule

`default_nettype wire

/* sv/rha_checker.sv */
// Port-level timing checks for the RGB histogram accumulator, with bind.
`default_nettype none

module rha_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] cmd,
    input wire logic       done
);

    logic take_read;
    logic take_pixel;

    assign take_read  = start && !busy && (cmd == rha_pkg::CMD_READ);
    assign take_pixel = start && !busy && (cmd == rha_pkg::CMD_PIXEL);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while not busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_read_reply: assert property (@(posedge clk) disable iff (!rst_n)
        take_read |=> busy ##1 done)
        else $error("read request did not reply on time");

    a_pixel_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        take_pixel |=> (busy && !done) ##1 !done)
        else $error("pixel request produced a result");

endmodule

bind rgb_histogram_accumulator rha_checker u_rha_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done)
);

`default_nettype wire
